/* rtl/u8v_pkg.sv */
// Package for the UTF-8 stream validator: status codes, offset limits and the
// per-buffer checking state record. No dependencies.
package u8v_pkg;

    localparam longint unsigned MAX_LEN = 64'd65536;
    localparam longint unsigned OFFSET_CAP_WIDE =
        ((MAX_LEN - 64'd1) < 64'd65535) ? (MAX_LEN - 64'd1) : 64'd65535;
    localparam logic [15:0] OFFSET_CAP = OFFSET_CAP_WIDE[15:0];

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_INVALID    = 2'd1,
        ST_INCOMPLETE = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  bytes_remaining;
        logic [7:0]  lead_value;
        logic        at_second_byte;
        logic        char_invalid;
        logic        failed;
        logic [15:0] fail_offset;
        logic [15:0] char_start;
        logic [15:0] byte_count;
    } t_state;

    localparam t_state STATE_RESET = '{
        bytes_remaining: 3'd0,
        lead_value:      8'd0,
        at_second_byte:  1'b0,
        char_invalid:    1'b0,
        failed:          1'b0,
        fail_offset:     16'd0,
        char_start:      16'd0,
        byte_count:      16'd0
    };

    typedef struct packed {
        t_status     status;
        logic [2:0]  bytes_needed;
        logic [15:0] char_offset;
    } t_result;

endpackage

/* rtl/u8v_if.sv */
// Valid/ready channel interfaces for the UTF-8 stream validator: the byte
// input channel and the result channel. Depends on u8v_pkg.
interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_result_if;
    import u8v_pkg::*;

    logic        valid;
    logic        ready;
    t_status     status;
    logic [2:0]  bytes_needed;
    logic [15:0] char_offset;

    modport source (output valid, output status, output bytes_needed, output char_offset,
                    input ready);
    modport sink   (input valid, input status, input bytes_needed, input char_offset,
                    output ready);
endinterface

/* rtl/u8v_char_check.sv */
// Next-state logic of the validator for one byte: lead and trailing byte rules,
// character completion, offset counting and the end-of-buffer verdict.
// Depends on u8v_pkg.
module u8v_char_check (
    input  u8v_pkg::t_state  i_state,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output u8v_pkg::t_state  o_state,
    output u8v_pkg::t_result o_result
);
    import u8v_pkg::*;

    function automatic logic [2:0] trail_count(input logic [7:0] b);
        logic [2:0] n;
        if (b < 8'hC0)      n = 3'd0;
        else if (b < 8'hE0) n = 3'd1;
        else if (b < 8'hF0) n = 3'd2;
        else if (b < 8'hF8) n = 3'd3;
        else if (b < 8'hFC) n = 3'd4;
        else                n = 3'd5;
        return n;
    endfunction

    function automatic logic first_trail_bad(input logic [7:0] lead, input logic [7:0] b);
        logic bad;
        if (b > 8'hBF) begin
            bad = 1'b1;
        end else begin
            unique case (lead)
                8'hE0:   bad = (b < 8'hA0);
                8'hED:   bad = (b > 8'h9F);
                8'hF0:   bad = (b < 8'h90);
                8'hF4:   bad = (b > 8'h8F);
                default: bad = (b < 8'h80);
            endcase
        end
        return bad;
    endfunction

    t_state n_state;
    logic   trail_bad;
    logic   char_done;

    always_comb begin
        n_state   = i_state;
        trail_bad = 1'b0;
        char_done = 1'b0;
        if (i_state.bytes_remaining == 3'd0) begin
            n_state.char_start      = i_state.byte_count;
            n_state.lead_value      = i_data_byte;
            n_state.bytes_remaining = trail_count(i_data_byte);
            n_state.at_second_byte  = 1'b1;
            n_state.char_invalid    = (i_data_byte >= 8'h80 && i_data_byte < 8'hC2) ||
                                      (i_data_byte > 8'hF4);
            char_done               = (trail_count(i_data_byte) == 3'd0);
        end else begin
            if (i_state.at_second_byte) begin
                trail_bad = first_trail_bad(i_state.lead_value, i_data_byte);
            end else begin
                trail_bad = (i_data_byte < 8'h80) || (i_data_byte > 8'hBF);
            end
            n_state.char_invalid    = i_state.char_invalid | trail_bad;
            n_state.at_second_byte  = 1'b0;
            n_state.bytes_remaining = i_state.bytes_remaining - 3'd1;
            char_done               = (i_state.bytes_remaining == 3'd1);
        end
        if (char_done && n_state.char_invalid && !i_state.failed) begin
            n_state.failed      = 1'b1;
            n_state.fail_offset = n_state.char_start;
        end
        if (i_state.byte_count < OFFSET_CAP) begin
            n_state.byte_count = i_state.byte_count + 16'd1;
        end
    end

    always_comb begin
        if (n_state.failed) begin
            o_result.status       = ST_INVALID;
            o_result.bytes_needed = 3'd0;
            o_result.char_offset  = n_state.fail_offset;
        end else if (n_state.bytes_remaining != 3'd0) begin
            o_result.status       = ST_INCOMPLETE;
            o_result.bytes_needed = n_state.bytes_remaining;
            o_result.char_offset  = n_state.char_start;
        end else begin
            o_result.status       = ST_VALID;
            o_result.bytes_needed = 3'd0;
            o_result.char_offset  = n_state.char_start;
        end
        o_state = i_last_byte ? STATE_RESET : n_state;
    end

endmodule

/* rtl/utf8_stream_validator_unit.sv */
// UTF-8 stream validator top level.
// A buffer arrives one byte per beat on i_byte; last_byte marks its final beat.
// Each byte is checked against RFC 3629 rules, keeping the legacy lead table in
// which 0xF8-0xFF leads announce four or five trailing bytes and always fail.
// Exactly one result beat leaves on o_result per buffer, after its last byte:
// status valid, invalid or incomplete, the missing byte count of an incomplete
// final character, and the offset of the deciding character (saturating).
// The input register holds each accepted byte; checking it updates the state
// and, for a final byte, loads the result register that drives o_result.
// Throughput: one byte per cycle unless a final byte waits on a full result
// register; the state update after the input register is combinational.
// When the receiver stalls, a waiting result holds; bytes that give no result
// still drain through, and input stops only when a final byte finds the result
// register full. Synchronous active-low reset empties both registers and clears
// the checking state, so the next byte starts a new buffer at offset zero.
// Depends on u8v_pkg, u8v_if and u8v_char_check.
module utf8_stream_validator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    u8v_byte_if.sink            i_byte,
    u8v_result_if.source        o_result
);
    import u8v_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    logic       r_out_valid;
    t_result    r_out;

    t_state     n_state;
    t_result    n_out;
    logic       advance;

    u8v_char_check u_check (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    assign advance      = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
        if (advance && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out.status;
    assign o_result.bytes_needed = r_out.bytes_needed;
    assign o_result.char_offset  = r_out.char_offset;

    a_need_incomplete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.status == ST_INCOMPLETE) == (r_out.bytes_needed != 3'd0)))
        else $error("bytes_needed disagrees with status");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_state.byte_count == 16'd0 && !r_state.failed))
        else $error("state not cleared after final byte");

    a_fail_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.failed |-> (r_state.fail_offset == 16'd0))
        else $error("fail offset set without a failure");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_count <= OFFSET_CAP)
        else $error("byte count beyond cap");

endmodule
